[sv/wbm_pkg.sv]
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types and codes of the word break matcher: the item layouts of the
// input and result channels, the action and status codes, and the control
// group that the top level hands to each dictionary cell.
// ----------------------------------------------------------------------------
package wbm_pkg;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DICT  = 2'd1;
    localparam logic [1:0] ACT_TEXT  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic       end_mark;
    } in_item_t;

    typedef struct packed {
        logic       breakable;
        logic       last_of_text;
        logic [1:0] status;
    } out_item_t;

    typedef struct packed {
        logic load_char;
        logic load_len;
        logic active;
    } cell_ctl_t;

endpackage

[sv/wbm_stream_if.sv]
// ----------------------------------------------------------------------------
// wbm_stream_if
// Valid/ready channel that carries one item of the given payload type.
// ----------------------------------------------------------------------------
interface wbm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/word_break_matcher.sv]
// ----------------------------------------------------------------------------
// word_break_matcher
// Streaming word-break test of text against a dictionary held in a row of
// word cells.
// ----------------------------------------------------------------------------
// Usage: items arrive on the chars channel. An item clears the dictionary,
// adds one character of a dictionary word, or carries one text character;
// end_mark flags the last character of a word or of a text. Every item gives
// exactly one result on the results channel. For a text character, breakable
// tells whether the text so far splits into stored words, and last_of_text
// marks the final answer. On the last character of a word, status reports a
// word dropped because the dictionary is full or the word is too long.
// One item is taken every cycle while chars.ready is high. Its result is
// registered in the result buffer, behind waiting results. The rate rests
// on the combinational loop through the row of cells, which compares all
// words against the text window at once and folds the hit into the reach
// history. A two-entry result buffer holds results while the receiver stalls;
// when it is full, chars.ready drops until a result is taken.
// Reset empties the dictionary and the buffer, zeroes the text window and
// makes the start position reachable. Stored characters need no clearing.
// ----------------------------------------------------------------------------
module word_break_matcher #(
    parameter int MAX_WORDS    = 16,
    parameter int MAX_WORD_LEN = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    wbm_stream_if.sink   chars,
    wbm_stream_if.source results
);
    import wbm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;

    logic [CNT_W-1:0]             word_count_reg;
    logic [CNT_W-1:0]             word_count_next;
    logic [LEN_W-1:0]             load_len_reg;
    logic [LEN_W-1:0]             load_len_next;
    logic                         load_ovf_reg;
    logic                         load_ovf_next;
    logic [MAX_WORD_LEN-1:0][7:0] win_reg;
    logic [MAX_WORD_LEN:0]        hist_reg;
    logic [MAX_WORD_LEN:0]        hist_next;

    in_item_t                     item;
    out_item_t                    result;
    logic                         push;
    logic                         buf_full;
    logic                         is_dict;
    logic                         is_text;
    logic                         len_room;
    logic                         ovf_eff;
    logic                         count_full;
    logic                         commit;
    logic                         hit;
    logic [MAX_WORD_LEN-1:0][7:0] new_win;
    logic [MAX_WORDS:0]           hit_chain;

    assign item         = chars.payload;
    assign chars.ready  = !buf_full;
    assign push         = chars.valid && chars.ready;
    assign is_dict      = item.action == ACT_DICT;
    assign is_text      = item.action == ACT_TEXT;
    assign len_room     = load_len_reg < LEN_W'(MAX_WORD_LEN);
    assign ovf_eff      = load_ovf_reg || !len_room;
    assign count_full   = word_count_reg == CNT_W'(MAX_WORDS);
    assign commit       = push && is_dict && item.end_mark && !ovf_eff && !count_full;

    always_comb
    begin
        new_win[0] = item.char_code;
        for (int k = 1; k < MAX_WORD_LEN; k++)
        begin
            new_win[k] = win_reg[k-1];
        end
    end

    assign hit_chain[0] = 1'b0;

    for (genvar w = 0; w < MAX_WORDS; w++)
    begin : g_cell
        cell_ctl_t ctl;

        assign ctl.load_char = push && is_dict && len_room
                               && (word_count_reg == CNT_W'(w));
        assign ctl.load_len  = commit && (word_count_reg == CNT_W'(w));
        assign ctl.active    = CNT_W'(w) < word_count_reg;

        wbm_cell #(
            .MAX_WORD_LEN (MAX_WORD_LEN),
            .LEN_W        (LEN_W),
            .IDX_W        (IDX_W)
        ) u_cell (
            .clk     (clk),
            .ctl     (ctl),
            .wr_pos  (load_len_reg[IDX_W-1:0]),
            .wr_char (item.char_code),
            .wr_len  (load_len_reg + LEN_W'(1)),
            .new_win (new_win),
            .hist    (hist_reg),
            .hit_in  (hit_chain[w]),
            .hit_out (hit_chain[w+1])
        );
    end

    assign hit = hit_chain[MAX_WORDS];

    always_comb
    begin
        word_count_next = word_count_reg;
        load_len_next   = load_len_reg;
        load_ovf_next   = load_ovf_reg;
        hist_next       = hist_reg;
        result          = '0;
        case (item.action)
            ACT_CLEAR:
            begin
                word_count_next = '0;
                load_len_next   = '0;
                load_ovf_next   = 1'b0;
            end
            ACT_DICT:
            begin
                if (len_room)
                begin
                    load_len_next = load_len_reg + LEN_W'(1);
                end
                else
                begin
                    load_ovf_next = 1'b1;
                end
                if (item.end_mark)
                begin
                    if (ovf_eff)
                    begin
                        result.status = ST_TOO_LONG;
                    end
                    else if (count_full)
                    begin
                        result.status = ST_FULL;
                    end
                    else
                    begin
                        word_count_next = word_count_reg + CNT_W'(1);
                    end
                    load_len_next = '0;
                    load_ovf_next = 1'b0;
                end
            end
            ACT_TEXT:
            begin
                result.breakable = hit;
                hist_next        = {hist_reg[MAX_WORD_LEN-1:0], hit};
                if (item.end_mark)
                begin
                    result.last_of_text = 1'b1;
                    hist_next           = (MAX_WORD_LEN + 1)'(1);
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            load_len_reg   <= '0;
            load_ovf_reg   <= 1'b0;
            win_reg        <= '0;
            hist_reg       <= (MAX_WORD_LEN + 1)'(1);
        end
        else if (push)
        begin
            word_count_reg <= word_count_next;
            load_len_reg   <= load_len_next;
            load_ovf_reg   <= load_ovf_next;
            hist_reg       <= hist_next;
            if (is_text)
            begin
                win_reg <= new_win;
            end
        end
    end

    wbm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (result),
        .full      (buf_full),
        .results   (results)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        word_count_reg <= CNT_W'(MAX_WORDS))
        else $error("Dictionary word count exceeds its bound.");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_len_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("Loading word length exceeds its bound.");

    a_text_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push && is_text && item.end_mark |=> hist_reg == (MAX_WORD_LEN + 1)'(1))
        else $error("Reach history did not restart after the end of a text.");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        push && (item.action == ACT_CLEAR) |=> word_count_reg == '0 && load_len_reg == '0)
        else $error("Clear item did not empty the dictionary.");
`endif

endmodule

[sv/wbm_cell.sv]
// ----------------------------------------------------------------------------
// wbm_cell
// One dictionary slot: holds the characters and length of one word, checks
// them against the newest text window and the reach history, and passes the
// running hit flag on to the next cell of the row.
// ----------------------------------------------------------------------------
module wbm_cell #(
    parameter int MAX_WORD_LEN = 8,
    parameter int LEN_W        = 4,
    parameter int IDX_W        = 3
) (
    input  logic                         clk,
    input  wbm_pkg::cell_ctl_t           ctl,
    input  logic [IDX_W-1:0]             wr_pos,
    input  logic [7:0]                   wr_char,
    input  logic [LEN_W-1:0]             wr_len,
    input  logic [MAX_WORD_LEN-1:0][7:0] new_win,
    input  logic [MAX_WORD_LEN:0]        hist,
    input  logic                         hit_in,
    output logic                         hit_out
);
    import wbm_pkg::*;

    logic [MAX_WORD_LEN-1:0][7:0] chars_reg;
    logic [LEN_W-1:0]             len_reg;
    logic                         chars_eq;
    logic                         reach;

    always_ff @(posedge clk)
    begin
        if (ctl.load_char)
        begin
            chars_reg[wr_pos] <= wr_char;
        end
        if (ctl.load_len)
        begin
            len_reg <= wr_len;
        end
    end

    always_comb
    begin
        logic [LEN_W-1:0] rel;
        chars_eq = 1'b1;
        for (int j = 0; j < MAX_WORD_LEN; j++)
        begin
            rel = len_reg - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < len_reg)
            begin
                if (chars_reg[j] != new_win[rel[IDX_W-1:0]])
                begin
                    chars_eq = 1'b0;
                end
            end
        end
    end

    assign reach   = (len_reg != '0) && hist[len_reg - LEN_W'(1)];
    assign hit_out = hit_in || (ctl.active && reach && chars_eq);

endmodule

[sv/wbm_out_buf.sv]
// ----------------------------------------------------------------------------
// wbm_out_buf
// Two-entry result buffer that decouples the result channel from the input
// side, so a new item is taken while an earlier result waits.
// ----------------------------------------------------------------------------
module wbm_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wbm_pkg::out_item_t  push_item,
    output logic                full,
    wbm_stream_if.source        results
);
    import wbm_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    out_item_t  slot0_reg;
    out_item_t  slot1_reg;
    logic       pop;

    assign pop             = results.valid && results.ready;
    assign results.valid   = count_reg != 2'd0;
    assign results.payload = slot0_reg;
    assign full            = count_reg == 2'd2;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && count_reg == 2'd1)
            begin
                slot0_reg <= push_item;
            end
            else
            begin
                slot0_reg <= slot1_reg;
            end
            if (push && count_reg == 2'd2)
            begin
                slot1_reg <= push_item;
            end
        end
        else if (push)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_reg <= push_item;
            end
            else
            begin
                slot1_reg <= push_item;
            end
        end
    end

endmodule

[tb/sv/word_break_matcher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_break_matcher_tb
// Self-checking bench for the word break matcher. Dictionary words and text
// are streamed in, and every item is run through a local predictor of the
// dictionary store, the text window and the reach bits. Each result is then
// compared with the oldest expected one. A few directed items cover the edge
// cases. Random sessions follow, which load dictionaries and then send texts
// built from those words, with noise mixed in. Both channels idle at random.
// ----------------------------------------------------------------------------
module word_break_matcher_tb;

    import wbm_pkg::*;

    localparam int MAX_WORDS    = 16;
    localparam int MAX_WORD_LEN = 8;
    localparam int RANDOM_ITEMS = 600;
    localparam int IDLE_LIMIT   = 2000;
    localparam int POOL_DEPTH   = 32;
    localparam int POOL_CHARS   = 12;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    wbm_stream_if #(.payload_t(in_item_t))  chars_if ();
    wbm_stream_if #(.payload_t(out_item_t)) results_if ();

    word_break_matcher #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    logic [7:0]            dict_chars [MAX_WORDS][MAX_WORD_LEN];
    int                    dict_len [MAX_WORDS];
    int                    dict_count;
    int                    load_len;
    bit                    load_too_long;
    logic [7:0]            text_window [MAX_WORD_LEN];
    logic [MAX_WORD_LEN:0] reach_bits;

    out_item_t expected_results [$];

    logic [7:0] pool_chars [POOL_DEPTH][POOL_CHARS];
    int         pool_len [POOL_DEPTH];
    int         pool_size   = 0;

    int error_count = 0;
    int items_sent  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_item_t predict_word_break(in_item_t it);
        out_item_t             r;
        logic [MAX_WORD_LEN:0] prior;
        bit                    hit;
        bit                    same;
        int                    len;
        r = '0;
        case (it.action)
            ACT_CLEAR:
            begin
                dict_count    = 0;
                load_len      = 0;
                load_too_long = 1'b0;
            end
            ACT_DICT:
            begin
                if (load_len < MAX_WORD_LEN)
                begin
                    if (dict_count < MAX_WORDS)
                        dict_chars[dict_count][load_len] = it.char_code;
                    load_len++;
                end
                else
                    load_too_long = 1'b1;
                if (it.end_mark)
                begin
                    if (load_too_long)
                        r.status = ST_TOO_LONG;
                    else if (dict_count >= MAX_WORDS)
                        r.status = ST_FULL;
                    else
                    begin
                        dict_len[dict_count] = load_len;
                        dict_count++;
                    end
                    load_len      = 0;
                    load_too_long = 1'b0;
                end
            end
            ACT_TEXT:
            begin
                prior = reach_bits;
                hit   = 1'b0;
                for (int k = MAX_WORD_LEN - 1; k > 0; k--)
                    text_window[k] = text_window[k - 1];
                text_window[0] = it.char_code;
                for (int w = 0; w < dict_count; w++)
                begin
                    len = dict_len[w];
                    if (prior[len - 1])
                    begin
                        same = 1'b1;
                        for (int k = 0; k < len; k++)
                            if (text_window[k] != dict_chars[w][len - 1 - k])
                                same = 1'b0;
                        if (same)
                            hit = 1'b1;
                    end
                end
                r.breakable = hit;
                reach_bits  = {prior[MAX_WORD_LEN-1:0], hit};
                if (it.end_mark)
                begin
                    r.last_of_text = 1'b1;
                    reach_bits     = (MAX_WORD_LEN + 1)'(1);
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, field, got, want);
        error_count++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result with no item pending", int'(got), 0);
            return;
        end
        want = expected_results.pop_front();
        if (got.breakable !== want.breakable)
            report_mismatch("breakable", int'(got.breakable), int'(want.breakable));
        if (got.last_of_text !== want.last_of_text)
            report_mismatch("last_of_text", int'(got.last_of_text), int'(want.last_of_text));
        if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
    endtask

    task automatic send_item(logic [1:0] act, logic [7:0] code, bit last);
        in_item_t it;
        it = '{action: act, char_code: code, end_mark: last};
        if (burst_left == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 250)
                                                     : $urandom_range(1, 20);
        end
        chars_if.valid   <= 1'b1;
        chars_if.payload <= it;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        expected_results.push_back(predict_word_break(it));
        items_sent++;
        burst_left--;
    endtask

    task automatic load_random_word();
        int         n;
        int         sel;
        logic [7:0] w [POOL_CHARS];
        sel = $urandom_range(0, 9);
        n = (sel == 0) ? MAX_WORD_LEN
          : (sel == 1) ? $urandom_range(MAX_WORD_LEN + 1, POOL_CHARS - 1)
          : $urandom_range(1, 3);
        foreach (w[k])
            w[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'h61 + 8'($urandom_range(0, 2));
        if ($urandom_range(0, 24) == 0)
        begin
            // A clear in the middle of a word throws the partial word away.
            send_item(ACT_DICT, w[0], 1'b0);
            send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            pool_size = 0;
        end
        for (int k = 0; k < n; k++)
            send_item(ACT_DICT, w[k], k == n - 1);
        if (pool_size < POOL_DEPTH)
        begin
            pool_chars[pool_size] = w;
            pool_len[pool_size]   = n;
            pool_size++;
        end
    endtask

    task automatic send_text_of_words();
        int         parts;
        int         p;
        int         len;
        logic [7:0] seq [$];
        parts = $urandom_range(1, 6);
        for (int i = 0; i < parts; i++)
        begin
            if (pool_size == 0)
            begin
                len = $urandom_range(1, 3);
                repeat (len)
                    seq.push_back(8'h61 + 8'($urandom_range(0, 2)));
            end
            else
            begin
                p = $urandom_range(0, pool_size - 1);
                for (int k = 0; k < pool_len[p]; k++)
                    seq.push_back(pool_chars[p][k]);
            end
            if ($urandom_range(0, 9) == 0)
                seq.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < seq.size(); i++)
        begin
            if ($urandom_range(0, 29) == 0)
                load_random_word();
            if ($urandom_range(0, 39) == 0)
                send_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            send_item(ACT_TEXT, seq[i], i == seq.size() - 1);
        end
    endtask

    task automatic test_unused_action();
        send_item(ACT_UNUSED, 8'hFF, 1'b1);
    endtask

    task automatic test_clear_while_loading();
        send_item(ACT_DICT, 8'h71, 1'b0);
        send_item(ACT_DICT, 8'h72, 1'b0);
        send_item(ACT_CLEAR, 8'h00, 1'b0);
    endtask

    task automatic test_word_limits();
        send_item(ACT_DICT, 8'hFF, 1'b1);
        send_item(ACT_DICT, 8'h00, 1'b1);
        for (int k = 0; k < MAX_WORD_LEN; k++)
            send_item(ACT_DICT, 8'(1 << k), k == MAX_WORD_LEN - 1);
        for (int k = 0; k <= MAX_WORD_LEN; k++)
            send_item(ACT_DICT, 8'h61 + 8'(k), k == MAX_WORD_LEN);
    endtask

    task automatic test_text_interleave_and_end();
        send_item(ACT_TEXT, 8'hFF, 1'b0);
        send_item(ACT_DICT, 8'h7A, 1'b1);
        send_item(ACT_TEXT, 8'h00, 1'b0);
        send_item(ACT_TEXT, 8'hFF, 1'b1);
    endtask

    task automatic test_random_sessions(int item_goal);
        int words;
        int texts;
        int stop_at;
        stop_at = items_sent + item_goal;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 7) != 0)
            begin
                send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                pool_size = 0;
            end
            if ($urandom_range(0, 19) == 0)
                send_text_of_words();
            words = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 20)
                                                : $urandom_range(1, 8);
            repeat (words)
                load_random_word();
            texts = $urandom_range(1, 4);
            repeat (texts)
                send_text_of_words();
        end
    endtask

    initial
    begin
        int rx_cycle;
        int stall_left;
        bit rdy;
        rx_cycle   = 0;
        stall_left = 0;
        results_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (results_if.valid && results_if.ready)
                check_result(results_if.payload);
            rx_cycle++;
            case ((rx_cycle / 150) % 4)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                2: rdy = ((rx_cycle % 7) < 2);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rdy = 1'b0;
                    end
                    else
                    begin
                        rdy = 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall_left = $urandom_range(5, 30);
                    end
                end
            endcase
            results_if.ready <= rdy;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("word_break_matcher_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n            <= 1'b0;
        chars_if.valid   <= 1'b0;
        chars_if.payload <= '0;
        dict_count    = 0;
        load_len      = 0;
        load_too_long = 1'b0;
        reach_bits    = (MAX_WORD_LEN + 1)'(1);
        foreach (text_window[k])
            text_window[k] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_unused_action();
        test_clear_while_loading();
        test_word_limits();
        test_text_interleave_and_end();
        test_random_sessions(RANDOM_ITEMS);

        chars_if.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("word_break_matcher_tb: PASS");
        else
            $display("word_break_matcher_tb: FAIL");
        $finish;
    end

endmodule
